// ===== sv/apmf_pkg.sv =====
// shared types and constants for the aging packet match filter
`default_nettype none
package apmf_pkg;

    localparam int unsigned IP_HEADER_BYTES = 20;
    localparam int unsigned KEY_W = 96;
    localparam logic [15:0] PERIOD_RESET = 16'd60;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] now_seconds;
        logic        is_icmp;
        logic [15:0] icmp_payload_len;
        logic [15:0] ip_ident;
        logic [15:0] ip_total_len;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_in_req;

    typedef struct packed {
        logic matched;
        logic store_full;
    } t_out_req;

    typedef struct packed {
        logic load;
        logic rotate;
        logic scan_start;
        logic scan_second;
        logic read;
        logic check;
        logic next;
        logic write_hit;
        logic write_miss;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic qualify;
        logic rot_due;
        logic hit;
        logic last;
        logic second;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/aging_packet_match_filter.sv =====
// top level of the aging packet match filter
// one request at a time; slots are scanned one by one from the key memory, each read then checked
// add: scans the newer generation only, ending early on a hit
// qualifying check: scans the older generation then the newer one, ending early on a hit
// non-qualifying check: skips the scan; next request accepted once the result is registered
// synchronous active-low reset clears count valid bits, older-generation select, deadline, period to 60
`default_nettype none
module aging_packet_match_filter import apmf_pkg::*; #(
    parameter int unsigned SLOTS_PER_GENERATION = 64,
    parameter int unsigned MAX_COUNT = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_req     i_in_req,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_req         o_out_req,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);
    t_cmd cmd;
    t_sts sts;

    apmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    apmf_dp #(
        .SLOTS_PER_GENERATION (SLOTS_PER_GENERATION),
        .MAX_COUNT            (MAX_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_req   (o_out_req)
    );
endmodule
`default_nettype wire

// ===== sv/apmf_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module apmf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/apmf_ctrl.sv =====
// sequencing state machine for add, rotate and lookup scans
`default_nettype none
module apmf_ctrl import apmf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_START, S_RD, S_CMP, S_HIT, S_MISS, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.action == ACT_ADD) begin
                    n_state = S_START;
                end else if (i_sts.qualify) begin
                    o_cmd.rotate = i_sts.rot_due;
                    n_state      = S_START;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_START: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_RD;
            end
            S_RD: begin
                o_cmd.read = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                o_cmd.check = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_HIT;
                end else if (!i_sts.last) begin
                    o_cmd.next = 1'b1;
                    n_state    = S_RD;
                end else if (i_sts.action == ACT_CHECK && !i_sts.second) begin
                    o_cmd.scan_second = 1'b1;
                    n_state           = S_RD;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_HIT: begin
                o_cmd.write_hit = 1'b1;
                n_state         = S_FIN;
            end
            S_MISS: begin
                o_cmd.write_miss = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== sv/apmf_dp.sv =====
// key and count stores, generation state and scan datapath
`default_nettype none
module apmf_dp import apmf_pkg::*; #(
    parameter int unsigned SLOTS_PER_GENERATION = 64,
    parameter int unsigned MAX_COUNT = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire t_in_req     i_in_req,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output t_out_req         o_out_req
);
    localparam int unsigned TOTAL = 2 * SLOTS_PER_GENERATION;
    localparam int unsigned AW = $clog2(TOTAL);
    localparam int unsigned IW = $clog2(SLOTS_PER_GENERATION);
    localparam int unsigned CW = $clog2(MAX_COUNT + 1);

    t_in_req          r_req;
    logic [15:0]      r_period;
    logic [31:0]      r_deadline;
    logic             r_older;
    logic [TOTAL-1:0] r_valid;
    logic             r_bank;
    logic [IW-1:0]    r_idx;
    logic             r_second;
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_hit_addr;
    logic [CW-1:0]    r_hit_cnt;
    logic             r_free_found;
    logic [AW-1:0]    r_free_addr;
    logic             r_res_matched;
    logic             r_res_full;
    t_out_req         r_out;

    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_rdata;
    logic [CW-1:0]    cnt_rdata;
    logic [CW-1:0]    eff_cnt;
    logic             match;
    logic             cnt_we;
    logic [AW-1:0]    cnt_waddr;
    logic [CW-1:0]    cnt_wdata;
    logic             key_we;
    logic [31:0]      limit;

    assign key     = {r_req.src_addr, r_req.dst_addr, r_req.ip_ident, r_req.ip_total_len};
    assign rd_addr = r_bank ? (AW'(SLOTS_PER_GENERATION) + AW'(r_idx)) : AW'(r_idx);
    assign eff_cnt = r_valid[r_rd_addr] ? cnt_rdata : '0;
    assign match   = (eff_cnt != '0) && (key_rdata == key);
    assign limit   = r_req.now_seconds - {16'd0, r_period};

    assign key_we = i_cmd.write_miss && (r_req.action == ACT_ADD) && r_free_found;
    assign cnt_we = i_cmd.write_hit || key_we;

    always_comb begin
        cnt_waddr = r_free_addr;
        cnt_wdata = CW'(1);
        if (i_cmd.write_hit) begin
            cnt_waddr = r_hit_addr;
            if (r_req.action == ACT_CHECK) begin
                cnt_wdata = r_hit_cnt - CW'(1);
            end else if (r_hit_cnt == CW'(MAX_COUNT)) begin
                cnt_wdata = r_hit_cnt;
            end else begin
                cnt_wdata = r_hit_cnt + CW'(1);
            end
        end
    end

    apmf_ram #(.WIDTH(KEY_W), .DEPTH(TOTAL)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_free_addr),
        .i_wdata (key),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    apmf_ram #(.WIDTH(CW), .DEPTH(TOTAL)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_deadline <= '0;
            r_older    <= 1'b0;
            r_valid    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (i_cmd.rotate) begin
                r_older    <= ~r_older;
                r_deadline <= r_req.now_seconds + {16'd0, r_period};
                for (int i = 0; i < TOTAL; i++) begin
                    if ((i >= SLOTS_PER_GENERATION) == r_older) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end
            if (key_we) begin
                r_valid[r_free_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req         <= i_in_req;
            r_res_matched <= 1'b0;
            r_res_full    <= 1'b0;
        end
        if (i_cmd.scan_start) begin
            r_bank       <= (r_req.action == ACT_CHECK) ? r_older : ~r_older;
            r_idx        <= '0;
            r_second     <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (i_cmd.scan_second) begin
            r_bank   <= ~r_bank;
            r_idx    <= '0;
            r_second <= 1'b1;
        end
        if (i_cmd.next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.read) begin
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.check) begin
            if (match) begin
                r_hit_addr <= r_rd_addr;
                r_hit_cnt  <= eff_cnt;
            end
            if (eff_cnt == '0 && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_addr  <= r_rd_addr;
            end
        end
        if (i_cmd.write_hit) begin
            r_res_matched <= (r_req.action == ACT_CHECK);
        end
        if (i_cmd.write_miss && r_req.action == ACT_ADD && !r_free_found) begin
            r_res_full <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.matched    <= r_res_matched;
            r_out.store_full <= r_res_full;
        end
    end

    assign o_sts.action  = r_req.action;
    assign o_sts.qualify = r_req.is_icmp && (r_req.icmp_payload_len > 16'(IP_HEADER_BYTES));
    assign o_sts.rot_due = (r_deadline <= limit);
    assign o_sts.hit     = match;
    assign o_sts.last    = (r_idx == IW'(SLOTS_PER_GENERATION - 1));
    assign o_sts.second  = r_second;
    assign o_out_req     = r_out;
endmodule
`default_nettype wire

// ===== sv/apmf_checker.sv =====
// port level checks for the aging packet match filter and their binding
`default_nettype none
module apmf_checker import apmf_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_req o_out_req
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_req.matched && o_out_req.store_full))
        else $error("match and full flagged together");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");
endmodule

bind aging_packet_match_filter apmf_checker u_apmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);
`default_nettype wire
